[design/tvm_pkg.sv]
// ----------------------------------------------------------------------------
// tvm_pkg: shared types and constants for the instruction executor
// Opcodes, status codes and the decoded instruction record that the decode
// front passes to the execute back through its queue.
// ----------------------------------------------------------------------------
package tvm_pkg;

  localparam int WORD_W   = 64;
  localparam int IMM_W    = 32;
  localparam int ADDR_MAX = 16;
  localparam int RIDX_W   = 3;
  localparam int QDEPTH   = 2;
  localparam int QPTR_W   = 1;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_AND  = 4'd1,
    OP_NOT  = 4'd2,
    OP_LDR  = 4'd3,
    OP_LD   = 4'd4,
    OP_STR  = 4'd5,
    OP_PUTC = 4'd6,
    OP_PUTD = 4'd7,
    OP_HALT = 4'd8
  } op_t;

  typedef enum logic [2:0] {
    ST_DONE   = 3'd0,
    ST_CHAR   = 3'd1,
    ST_DEC    = 3'd2,
    ST_HALT   = 3'd3,
    ST_BADOP  = 3'd4,
    ST_BADREG = 3'd5
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic                bad_op;
    logic                bad_reg;
    logic                use_imm;
    logic [RIDX_W-1:0]   dst;
    logic [RIDX_W-1:0]   src1;
    logic [RIDX_W-1:0]   src2;
    logic [IMM_W-1:0]    imm;
    logic [ADDR_MAX-1:0] addr;
  } exec_req_t;

  typedef struct packed {
    logic clr_busy;
    logic halted;
  } exec_stat_t;

endpackage

[design/tvm_if.sv]
// ----------------------------------------------------------------------------
// tvm_if: valid/ready channels of the instruction executor
// The instruction channel and the result channel, each with a source and a
// sink modport.
// ----------------------------------------------------------------------------
interface tvm_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] instruction;

  modport source (output valid, output instruction, input ready);
  modport sink (input valid, input instruction, output ready);
endinterface

interface tvm_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_value;

  modport source (output valid, output status, output out_value, input ready);
  modport sink (input valid, input status, input out_value, output ready);
endinterface

[design/tvm_front.sv]
// ----------------------------------------------------------------------------
// tvm_front: instruction decode and issue queue
// Accepts instruction beats, splits them into fields, flags bad opcodes and
// bad register indexes, and holds the decoded records in a two-entry queue.
// ----------------------------------------------------------------------------
module tvm_front
  import tvm_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          enable,
  tvm_in_if.sink        in_ch,
  output exec_req_t     q_head,
  output logic          q_valid,
  input  logic          q_pop
);

  logic [63:0] w;
  logic [3:0]  op_raw;
  logic [3:0]  d_raw;
  logic [3:0]  s1_raw;
  logic [3:0]  s2_raw;
  exec_req_t   dec;

  exec_req_t         ent_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QPTR_W:0]   count_r;
  logic [QPTR_W:0]   count_nxt;
  logic              push;

  assign w      = in_ch.instruction;
  assign op_raw = w[63:60];
  assign d_raw  = w[59:56];
  assign s1_raw = w[55:52];
  assign s2_raw = w[51:48];

  always_comb begin
    dec         = '0;
    dec.op      = op_t'(op_raw);
    dec.dst     = d_raw[RIDX_W-1:0];
    dec.src1    = s1_raw[RIDX_W-1:0];
    dec.src2    = s2_raw[RIDX_W-1:0];
    dec.imm     = w[IMM_W-1:0];
    dec.addr    = w[ADDR_MAX-1:0];
    dec.bad_op  = 1'b0;
    dec.bad_reg = 1'b0;
    dec.use_imm = 1'b0;
    case (op_t'(op_raw))
      OP_ADD, OP_AND: begin
        dec.use_imm = w[47];
        dec.bad_reg = d_raw[3] | s1_raw[3] | (~w[47] & s2_raw[3]);
      end
      OP_NOT: begin
        dec.bad_reg = d_raw[3] | s1_raw[3];
      end
      OP_LDR: begin
        dec.use_imm = w[51];
        dec.bad_reg = d_raw[3] | (~w[51] & s1_raw[3]);
      end
      OP_LD, OP_STR: begin
        dec.bad_reg = d_raw[3];
      end
      OP_PUTC, OP_PUTD, OP_HALT: begin
        dec.bad_reg = 1'b0;
      end
      default: begin
        dec.bad_op = 1'b1;
      end
    endcase
  end

  assign in_ch.ready = enable && (count_r != (QPTR_W + 1)'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_head      = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= dec;
    end
  end

endmodule

[design/tvm_back.sv]
// ----------------------------------------------------------------------------
// tvm_back: execute stage, register file, data memory and result register
// Executes one decoded instruction per cycle against the register file and
// the data memory while no memory clear runs and no result beat waits to be
// taken, forwards load data, and holds the result beat until taken.
module tvm_back
  import tvm_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  exec_req_t  req,
  input  logic       req_valid,
  output logic       req_pop,
  output exec_stat_t stat,
  tvm_out_if.source  out_ch
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WORD_W-1:0]    rf_r [8];
  logic [WORD_W-1:0]    mem [DEPTH];
  logic [WORD_W-1:0]    mem_rdata_r;
  logic                 ld_pend_r;
  logic [RIDX_W-1:0]    ld_dst_r;
  logic                 halted_r;
  logic                 halted_nxt;
  logic                 clr_busy_r;
  logic [ADDR_BITS-1:0] clr_addr_r;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  status_t              status_r;
  logic [WORD_W-1:0]    value_r;

  logic                 fire;
  logic [WORD_W-1:0]    s1v;
  logic [WORD_W-1:0]    s2v;
  logic [WORD_W-1:0]    dv;
  logic [WORD_W-1:0]    r0v;
  logic [WORD_W-1:0]    opb;
  status_t              st;
  logic [WORD_W-1:0]    val;
  logic                 rf_we;
  logic [WORD_W-1:0]    rf_wd;
  logic                 str_en;
  logic                 ld_en;
  logic                 halt_en;
  logic                 mem_we;
  logic [ADDR_BITS-1:0] mem_waddr;
  logic [WORD_W-1:0]    mem_wdata;
  logic [ADDR_BITS-1:0] req_addr;

  assign fire     = req_valid && !clr_busy_r && (!out_valid_r || out_ch.ready);
  assign req_pop  = fire;
  assign req_addr = req.addr[ADDR_BITS-1:0];

  assign s1v = (ld_pend_r && ld_dst_r == req.src1) ? mem_rdata_r : rf_r[req.src1];
  assign s2v = (ld_pend_r && ld_dst_r == req.src2) ? mem_rdata_r : rf_r[req.src2];
  assign dv  = (ld_pend_r && ld_dst_r == req.dst) ? mem_rdata_r : rf_r[req.dst];
  assign r0v = (ld_pend_r && ld_dst_r == '0) ? mem_rdata_r : rf_r[0];
  assign opb = req.use_imm ? {{(WORD_W - IMM_W){1'b0}}, req.imm} : s2v;

  always_comb begin
    st      = ST_DONE;
    val     = '0;
    rf_we   = 1'b0;
    rf_wd   = '0;
    str_en  = 1'b0;
    ld_en   = 1'b0;
    halt_en = 1'b0;
    if (halted_r) begin
      st = ST_HALT;
    end else if (req.bad_op) begin
      st = ST_BADOP;
    end else if (req.bad_reg) begin
      st = ST_BADREG;
    end else begin
      case (req.op)
        OP_ADD: begin
          rf_we = 1'b1;
          rf_wd = s1v + opb;
        end
        OP_AND: begin
          rf_we = 1'b1;
          rf_wd = s1v & opb;
        end
        OP_NOT: begin
          rf_we = 1'b1;
          rf_wd = ~s1v;
        end
        OP_LDR: begin
          rf_we = 1'b1;
          rf_wd = req.use_imm ? {{(WORD_W - IMM_W){1'b0}}, req.imm} : s1v;
        end
        OP_LD: begin
          ld_en = 1'b1;
        end
        OP_STR: begin
          str_en = 1'b1;
        end
        OP_PUTC: begin
          st  = ST_CHAR;
          val = r0v;
        end
        OP_PUTD: begin
          st  = ST_DEC;
          val = r0v;
        end
        OP_HALT: begin
          st      = ST_HALT;
          halt_en = 1'b1;
        end
        default: begin
          st = ST_BADOP;
        end
      endcase
    end
  end

  always_comb begin
    mem_we    = clr_busy_r || (fire && str_en);
    mem_waddr = clr_busy_r ? clr_addr_r : req_addr;
    mem_wdata = clr_busy_r ? '0 : dv;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (fire && ld_en) begin
      mem_rdata_r <= mem[req_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      clr_addr_r <= clr_addr_r + 1'b1;
      if (clr_addr_r == '1) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        rf_r[i] <= '0;
      end
      ld_pend_r <= 1'b0;
      ld_dst_r  <= '0;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (fire && rf_we && req.dst == RIDX_W'(i)) begin
          rf_r[i] <= rf_wd;
        end else if (ld_pend_r && ld_dst_r == RIDX_W'(i)) begin
          rf_r[i] <= mem_rdata_r;
        end
      end
      ld_pend_r <= fire && ld_en;
      ld_dst_r  <= req.dst;
    end
  end

  assign halted_nxt    = halted_r || (fire && halt_en);
  assign out_valid_nxt = fire || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= st;
      value_r  <= val;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.out_value = value_r;

  assign stat.clr_busy = clr_busy_r;
  assign stat.halted   = halted_r;

endmodule

[design/toy_vm_instruction_executor.sv]
// ----------------------------------------------------------------------------
// toy_vm_instruction_executor: small register machine instruction executor
// Takes one 64-bit instruction per beat on in_ch and returns one result beat
// (status, out_value) per instruction on out_ch, in order.
//
// Both channels use valid/ready; a beat moves when both are high.
// A decode front classifies each instruction into a two-entry queue, and
// the execute back retires one queued instruction per cycle into the
// result register while no result waits on out_ch. A beat passes a queue
// entry and then the result register on its way to out_ch; throughput is
// one instruction per cycle while out_ch.ready is high, including loads,
// whose data is forwarded from the registered memory read port. After reset
// the 2**ADDR_BITS memory words are cleared one per cycle, in_ch.ready low.
// Registers and the halt flag clear at reset. When out_ch.ready is low the
// result is held, execution pauses, and the queue absorbs up to two more
// instruction beats before in_ch.ready drops.
// ----------------------------------------------------------------------------
module toy_vm_instruction_executor
  import tvm_pkg::*;
#(
  parameter int ADDR_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  tvm_in_if.sink    in_ch,
  tvm_out_if.source out_ch
);

  exec_req_t  q_head;
  logic       q_valid;
  logic       q_pop;
  exec_stat_t stat;

  tvm_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .enable (!stat.clr_busy),
    .in_ch  (in_ch),
    .q_head (q_head),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  tvm_back #(
    .ADDR_BITS(ADDR_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (q_head),
    .req_valid(q_valid),
    .req_pop  (q_pop),
    .stat     (stat),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clr_busy |-> !in_ch.ready)
    else $error("instruction beat possible during memory clear");

  a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> q_valid)
    else $error("accepted beat missing from queue");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stat.halted |=> stat.halted)
    else $error("halt flag dropped without reset");

  a_halted_result: assert property (@(posedge clk) disable iff (!rst_n)
    (stat.halted && out_ch.valid) |-> (out_ch.status == ST_HALT))
    else $error("non-halt result after halt");
`endif

endmodule

[tb/tb_toy_vm_instruction_executor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_toy_vm_instruction_executor: self-checking bench for the instruction executor
// A short directed program checks reset state, immediate extremes, every
// opcode and the bad-register and bad-opcode cases, then random instruction
// streams run against the register file and data memory. The HALT behavior
// is checked last. Every result beat is compared with a fixed expectation
// or with the bench's own execution of the instruction stream, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_toy_vm_instruction_executor;
  import tvm_pkg::*;

  localparam int ADDR_BITS = 16;
  localparam logic [3:0] OP_UNDEF_LO = 4'd9;
  localparam logic [3:0] OP_UNDEF_HI = 4'd15;
  localparam int N_RANDOM = 1800;
  localparam int LONG_HOLD = 64;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_SHOWN = 10;

  typedef struct {
    status_t     status;
    logic [63:0] value;
  } result_t;

  typedef struct {
    logic [63:0] insn;
    bit          fixed;
    status_t     status;
    logic [63:0] value;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  tvm_in_if  in_ch ();
  tvm_out_if out_ch ();

  toy_vm_instruction_executor #(.ADDR_BITS(ADDR_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  logic [63:0] gpr [8];
  logic [63:0] mem_img [int unsigned];
  bit          vm_halted;

  result_t     results_due [$];
  row_t        dir_rows [$];
  int          n_issued;
  int          n_checked;
  int          n_mismatch;
  int          op_count [16];
  bit          hold_req;
  bit          hold_done;

  logic [15:0] addr_pool [8] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000,
                                 16'h00FF, 16'h1234, 16'h7FFF, 16'hFF00};

  function automatic logic [63:0] insn(input logic [3:0] opc, input logic [3:0] d,
                                       input logic [3:0] s1, input logic [3:0] s2,
                                       input logic f, input logic [31:0] imm);
    return {opc, d, s1, s2, f, 15'd0, imm};
  endfunction

  function automatic void known(input logic [63:0] w, input status_t st,
                                input logic [63:0] v);
    dir_rows.push_back('{insn: w, fixed: 1'b1, status: st, value: v});
  endfunction

  function automatic void predicted(input logic [63:0] w);
    dir_rows.push_back('{insn: w, fixed: 1'b0, status: ST_DONE, value: 64'd0});
  endfunction

  function automatic logic [63:0] mem_read(input logic [ADDR_BITS-1:0] a);
    return mem_img.exists(a) ? mem_img[a] : 64'd0;
  endfunction

  function automatic result_t execute(input logic [63:0] w);
    logic [3:0]           opc;
    logic [3:0]           d;
    logic [3:0]           s1;
    logic [3:0]           s2;
    logic [63:0]          b;
    logic [ADDR_BITS-1:0] a;
    result_t              r;
    opc = w[63:60];
    d = w[59:56];
    s1 = w[55:52];
    s2 = w[51:48];
    a = w[ADDR_BITS-1:0];
    r.status = ST_DONE;
    r.value = 64'd0;
    if (vm_halted) begin
      r.status = ST_HALT;
    end else begin
      case (opc)
        OP_ADD, OP_AND: begin
          if (d[3] || s1[3] || (!w[47] && s2[3])) begin
            r.status = ST_BADREG;
          end else begin
            b = w[47] ? {32'd0, w[31:0]} : gpr[s2[2:0]];
            gpr[d[2:0]] = (opc == OP_ADD) ? gpr[s1[2:0]] + b : gpr[s1[2:0]] & b;
          end
        end
        OP_NOT: begin
          if (d[3] || s1[3]) r.status = ST_BADREG;
          else gpr[d[2:0]] = ~gpr[s1[2:0]];
        end
        OP_LDR: begin
          if (d[3] || (!w[51] && s1[3])) r.status = ST_BADREG;
          else gpr[d[2:0]] = w[51] ? {32'd0, w[31:0]} : gpr[s1[2:0]];
        end
        OP_LD: begin
          if (d[3]) r.status = ST_BADREG;
          else gpr[d[2:0]] = mem_read(a);
        end
        OP_STR: begin
          if (d[3]) r.status = ST_BADREG;
          else mem_img[a] = gpr[d[2:0]];
        end
        OP_PUTC: begin
          r.status = ST_CHAR;
          r.value = gpr[0];
        end
        OP_PUTD: begin
          r.status = ST_DEC;
          r.value = gpr[0];
        end
        OP_HALT: begin
          r.status = ST_HALT;
          vm_halted = 1'b1;
        end
        default: r.status = ST_BADOP;
      endcase
    end
    return r;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 50);
  endfunction

  function automatic logic [3:0] reg_field();
    return ($urandom_range(0, 99) < 95) ? 4'($urandom_range(0, 7))
                                        : 4'($urandom_range(8, 15));
  endfunction

  function automatic logic [63:0] rand_insn();
    logic [63:0] w;
    logic [3:0]  opc;
    w = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 4) opc = 4'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
    else opc = 4'($urandom_range(int'(OP_ADD), int'(OP_PUTD)));
    w[63:60] = opc;
    w[59:56] = reg_field();
    w[55:52] = reg_field();
    if (opc != OP_LDR) w[51:48] = reg_field();
    if ((opc == OP_LD || opc == OP_STR) && $urandom_range(0, 3) != 0)
      w[15:0] = addr_pool[$urandom_range(0, 7)];
    return w;
  endfunction

  task automatic issue(input logic [63:0] w, input bit fixed, input result_t fixed_res,
                       input int gap);
    result_t r;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.instruction <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    r = execute(w);
    results_due.push_back(fixed ? fixed_res : r);
    n_issued++;
    op_count[w[63:60]]++;
  endtask

  task automatic issue_rows(input int first, input int last);
    result_t fr;
    for (int i = first; i < last; i++) begin
      fr.status = dir_rows[i].status;
      fr.value = dir_rows[i].value;
      issue(dir_rows[i].insn, dir_rows[i].fixed, fr, idle_len());
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (results_due.size() != 0);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (results_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= MAX_SHOWN)
          $display("unexpected result beat: status %0d value %h",
                   out_ch.status, out_ch.out_value);
      end else begin
        e = results_due.pop_front();
        n_checked++;
        if (out_ch.status !== e.status || out_ch.out_value !== e.value) begin
          n_mismatch++;
          if (n_mismatch <= MAX_SHOWN)
            $display("result %0d: expected status %0d value %h, got status %0d value %h",
                     n_checked, e.status, e.value, out_ch.status, out_ch.out_value);
        end
      end
    end
  end

  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      n = hold_req ? LONG_HOLD : idle_len();
      if (hold_req) begin
        hold_req = 1'b0;
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        hold_done = 1'b1;
      end else if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      repeat (($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int      n_head;
    int      gap;
    result_t none;
    none.status = ST_DONE;
    none.value = 64'd0;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.instruction <= 64'd0;
    for (int i = 0; i < 8; i++) gpr[i] = 64'd0;
    vm_halted = 1'b0;

    known(insn(OP_PUTD, 0, 0, 0, 0, 0), ST_DEC, 64'd0);
    known(insn(OP_PUTC, 0, 0, 0, 0, 0), ST_CHAR, 64'd0);
    known(insn(OP_LD, 1, 0, 0, 0, 32'hABCD_FFFF), ST_DONE, 64'd0);
    known(insn(OP_LDR, 0, 0, 4'h8, 0, 32'hFFFF_FFFF), ST_DONE, 64'd0);
    known(insn(OP_PUTD, 0, 0, 0, 0, 0), ST_DEC, 64'h0000_0000_FFFF_FFFF);
    predicted(insn(OP_ADD, 0, 0, 0, 1, 32'hFFFF_FFFF));
    predicted(insn(OP_NOT, 1, 0, 0, 0, 0));
    predicted(insn(OP_ADD, 2, 1, 1, 0, 0));
    predicted(insn(OP_AND, 3, 2, 0, 1, 32'h8000_0001));
    predicted(insn(OP_LDR, 7, 1, 0, 0, 0));
    known(insn(OP_STR, 7, 0, 0, 0, 32'h0000_FFFF), ST_DONE, 64'd0);
    known(insn(OP_STR, 2, 0, 0, 0, 32'hFFFF_0000), ST_DONE, 64'd0);
    predicted(insn(OP_LD, 0, 0, 0, 0, 32'h0000_0000));
    predicted(insn(OP_PUTC, 0, 0, 0, 0, 0));
    known(insn(OP_ADD, 8, 0, 0, 0, 0), ST_BADREG, 64'd0);
    predicted(insn(OP_ADD, 6, 3, 4'hF, 1, 32'h0000_0001));
    known(insn(OP_AND, 6, 3, 4'h9, 0, 0), ST_BADREG, 64'd0);
    known(insn(OP_LDR, 6, 4'hF, 4'h8, 0, 32'h5A5A_5A5A), ST_DONE, 64'd0);
    known(insn(OP_LDR, 6, 4'h8, 0, 0, 0), ST_BADREG, 64'd0);
    known(insn(OP_NOT, 2, 4'hA, 0, 0, 0), ST_BADREG, 64'd0);
    known(insn(OP_STR, 4'hC, 0, 0, 0, 32'h0000_0001), ST_BADREG, 64'd0);
    known(insn(OP_UNDEF_LO, 0, 0, 0, 0, 0), ST_BADOP, 64'd0);
    known(insn(OP_UNDEF_HI, 4'hF, 4'hF, 4'hF, 1, 32'hFFFF_FFFF), ST_BADOP, 64'd0);
    predicted(insn(OP_PUTD, 0, 0, 0, 0, 0));
    n_head = dir_rows.size();
    known(insn(OP_HALT, 0, 0, 0, 0, 0), ST_HALT, 64'd0);
    known(insn(OP_PUTD, 0, 0, 0, 0, 0), ST_HALT, 64'd0);
    known(insn(OP_LDR, 0, 0, 4'h8, 0, 32'h0000_0001), ST_HALT, 64'd0);
    known(insn(OP_UNDEF_HI, 0, 0, 0, 0, 0), ST_HALT, 64'd0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    issue_rows(0, n_head);
    drain_results();

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 500) begin
        hold_req = 1'b1;
        hold_done = 1'b0;
        while (!hold_done) issue(rand_insn(), 1'b0, none, 0);
      end
      if (i == 1100) drain_results();
      gap = ((i % 150) < 40) ? 0 : idle_len();
      issue(rand_insn(), 1'b0, none, gap);
    end

    issue_rows(n_head, dir_rows.size());
    in_ch.valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d instructions sent, %0d results checked, %0d mismatches",
             n_issued, n_checked, n_mismatch);
    $display("opcode mix ADD %0d AND %0d NOT %0d LDR %0d LD %0d STR %0d PUTC %0d PUTD %0d",
             op_count[OP_ADD], op_count[OP_AND], op_count[OP_NOT], op_count[OP_LDR],
             op_count[OP_LD], op_count[OP_STR], op_count[OP_PUTC], op_count[OP_PUTD]);
    if (n_mismatch == 0 && results_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("timeout with %0d results outstanding", results_due.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule
